@@ hw/rtl/uer4_pkg.sv @@
`timescale 1ns / 1ps

package uer4_pkg;

   typedef enum logic [0:0] {
      OP_CAPTURE = 1'b0,
      OP_TICK    = 1'b1
   } opcode_type;

   localparam int CHAN_FIELD_BITS  = 2;
   localparam int CAPTURE_BITS     = 16;
   localparam int DIST_BITS        = 11;
   localparam int LIMIT_BITS       = 11;

   localparam logic [LIMIT_BITS-1:0] JUMP_LIMIT_RESET = 11'd100;
   localparam logic [DIST_BITS-1:0]  DIST_MAX         = 11'd2047;

   // pulse width in microseconds per centimetre
   localparam int CM_DIVISOR  = 58;
   // widths at or above this saturate the distance
   localparam int SAT_WIDTH   = (2048 * CM_DIVISOR);
   localparam int RECIP_BITS  = 17;
   localparam int RECIP_SHIFT = 23;
   localparam logic [17:0] CM_RECIP = 18'd144632;

endpackage

@@ hw/rtl/ultrasonic_echo_ranger_4ch_core.sv @@
`timescale 1ns / 1ps

// multi-channel ultrasonic echo ranger
//
// request channel (req_valid / req_stall): one transfer per echo edge capture or
// polling tick. a capture carries the channel and the timer stamp latched at the
// edge; each channel alternates rising and falling edges, and a falling edge
// produces a distance in centimetres. a tick returns the next channel to trigger.
// response channel (rsp_valid / rsp_stall): exactly one transfer per request.
// a request taken into the input register has its response registered in the
// response register when the input register advances; it waits there while a
// valid response is held by rsp_stall. throughput: one request per cycle while
// no held response stalls, set by the single register-to-register pass (stamp
// subtract, reciprocal multiply for the divide by 58, filter compare). when
// rsp_stall is high a valid response register holds; the input register keeps
// accepting until it is full, then req_stall follows rsp_stall.
// reset (synchronous, active high) clears all channel phases, stamps, distances,
// the trigger pointer and both valids, and sets the jump limit to 100.
// csr_write_enable writes csr_write_data into the jump limit; write it only idle.

module ultrasonic_echo_ranger_4ch_core
   import uer4_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int STAMP_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [CHAN_FIELD_BITS-1:0]  req_channel,
   input  logic [CAPTURE_BITS-1:0]     req_capture_value,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [CHAN_FIELD_BITS-1:0]  rsp_out_channel,
   output logic                        rsp_trigger_fire,
   output logic                        rsp_measurement_done,
   output logic [DIST_BITS-1:0]        rsp_raw_distance,
   output logic [DIST_BITS-1:0]        rsp_filtered_distance,

   input  logic                        csr_write_enable,
   input  logic [LIMIT_BITS-1:0]       csr_write_data
);

   localparam int ChanBits = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int WideBits = (STAMP_BITS > RECIP_BITS) ? STAMP_BITS : RECIP_BITS;
   localparam int ProdBits = RECIP_BITS + 18;

   // input register
   logic                        in_valid_ff, in_valid_in;
   opcode_type                  in_opcode_ff;
   logic [CHAN_FIELD_BITS-1:0]  in_channel_ff;
   logic [CAPTURE_BITS-1:0]     in_capture_ff;

   // per-channel state, trigger pointer and jump limit
   logic                        edge_phase_ff      [NUM_CHANNELS];
   logic                        edge_phase_in      [NUM_CHANNELS];
   logic [STAMP_BITS-1:0]       start_stamp_ff     [NUM_CHANNELS];
   logic [STAMP_BITS-1:0]       start_stamp_in     [NUM_CHANNELS];
   logic [DIST_BITS-1:0]        newest_distance_ff [NUM_CHANNELS];
   logic [DIST_BITS-1:0]        newest_distance_in [NUM_CHANNELS];
   logic [DIST_BITS-1:0]        prior_distance_ff  [NUM_CHANNELS];
   logic [DIST_BITS-1:0]        prior_distance_in  [NUM_CHANNELS];
   logic [ChanBits-1:0]         trigger_pointer_ff, trigger_pointer_in;
   logic [LIMIT_BITS-1:0]       jump_limit_ff, jump_limit_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CHAN_FIELD_BITS-1:0]  rsp_channel_ff, rsp_channel_in;
   logic                        rsp_fire_ff, rsp_fire_in;
   logic                        rsp_done_ff, rsp_done_in;
   logic [DIST_BITS-1:0]        rsp_raw_ff, rsp_raw_in;
   logic [DIST_BITS-1:0]        rsp_filt_ff, rsp_filt_in;

   logic                        advance;
   logic [ChanBits-1:0]         ch_idx;
   logic                        ch_ok;
   logic                        cur_phase;
   logic [STAMP_BITS-1:0]       stamp;
   logic [STAMP_BITS-1:0]       cur_start;
   logic [STAMP_BITS-1:0]       pulse_width;
   logic [WideBits-1:0]         pulse_wide;
   logic                        dist_sat;
   logic [ProdBits-1:0]         product;
   logic [DIST_BITS-1:0]        new_dist;
   logic [DIST_BITS-1:0]        old_dist;
   logic [DIST_BITS-1:0]        dist_diff;
   logic [DIST_BITS-1:0]        filt_dist;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   // width and distance
   assign ch_idx    = ChanBits'(in_channel_ff);
   assign ch_ok     = 32'(in_channel_ff) < NUM_CHANNELS;
   assign cur_phase = ch_ok ? edge_phase_ff[ch_idx] : 1'b0;
   assign cur_start = ch_ok ? start_stamp_ff[ch_idx] : '0;
   assign old_dist  = ch_ok ? newest_distance_ff[ch_idx] : '0;
   assign stamp     = STAMP_BITS'(in_capture_ff);

   assign pulse_width = (stamp > cur_start) ? (stamp - cur_start)
                                            : ((~cur_start) + stamp);
   assign pulse_wide  = WideBits'(pulse_width);
   assign dist_sat    = pulse_wide >= WideBits'(SAT_WIDTH);
   assign product     = ProdBits'(pulse_wide[RECIP_BITS-1:0]) * ProdBits'(CM_RECIP);
   assign new_dist    = dist_sat ? DIST_MAX
                                 : product[RECIP_SHIFT+DIST_BITS-1:RECIP_SHIFT];
   assign dist_diff   = (new_dist > old_dist) ? (new_dist - old_dist)
                                              : (old_dist - new_dist);
   assign filt_dist   = (dist_diff > jump_limit_ff) ? '0 : old_dist;

   always_comb begin
      edge_phase_in      = edge_phase_ff;
      start_stamp_in     = start_stamp_ff;
      newest_distance_in = newest_distance_ff;
      prior_distance_in  = prior_distance_ff;
      trigger_pointer_in = trigger_pointer_ff;
      jump_limit_in      = csr_write_enable ? csr_write_data : jump_limit_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_channel_in = rsp_channel_ff;
      rsp_fire_in    = rsp_fire_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_filt_in    = rsp_filt_ff;

      if (advance) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = in_channel_ff;
         rsp_fire_in    = 1'b0;
         rsp_done_in    = 1'b0;
         rsp_raw_in     = '0;
         rsp_filt_in    = '0;
         case (in_opcode_ff)
            OP_TICK: begin
               rsp_channel_in = CHAN_FIELD_BITS'(trigger_pointer_ff);
               rsp_fire_in    = 1'b1;
               trigger_pointer_in = (32'(trigger_pointer_ff) >= NUM_CHANNELS - 1)
                                    ? '0 : trigger_pointer_ff + 1'b1;
            end
            OP_CAPTURE: begin
               if (ch_ok) begin
                  if (!cur_phase) begin
                     start_stamp_in[ch_idx] = stamp;
                     edge_phase_in[ch_idx]  = 1'b1;
                  end else begin
                     prior_distance_in[ch_idx]  = old_dist;
                     newest_distance_in[ch_idx] = new_dist;
                     edge_phase_in[ch_idx]      = 1'b0;
                     rsp_done_in = 1'b1;
                     rsp_raw_in  = new_dist;
                     rsp_filt_in = filt_dist;
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         trigger_pointer_ff <= '0;
         jump_limit_ff      <= JUMP_LIMIT_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            edge_phase_ff[i]      <= 1'b0;
            start_stamp_ff[i]     <= '0;
            newest_distance_ff[i] <= '0;
            prior_distance_ff[i]  <= '0;
         end
      end else begin
         in_valid_ff        <= in_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         trigger_pointer_ff <= trigger_pointer_in;
         jump_limit_ff      <= jump_limit_in;
         edge_phase_ff      <= edge_phase_in;
         start_stamp_ff     <= start_stamp_in;
         newest_distance_ff <= newest_distance_in;
         prior_distance_ff  <= prior_distance_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_opcode_ff  <= opcode_type'(req_opcode);
         in_channel_ff <= req_channel;
         in_capture_ff <= req_capture_value;
      end
      rsp_channel_ff <= rsp_channel_in;
      rsp_fire_ff    <= rsp_fire_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_raw_ff     <= rsp_raw_in;
      rsp_filt_ff    <= rsp_filt_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_channel       = rsp_channel_ff;
   assign rsp_trigger_fire      = rsp_fire_ff;
   assign rsp_measurement_done  = rsp_done_ff;
   assign rsp_raw_distance      = rsp_raw_ff;
   assign rsp_filtered_distance = rsp_filt_ff;

endmodule

@@ hw/rtl/uer4_checker.sv @@
`timescale 1ns / 1ps

module uer4_checker
   import uer4_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [CHAN_FIELD_BITS-1:0]  rsp_out_channel,
   input logic                        rsp_trigger_fire,
   input logic                        rsp_measurement_done,
   input logic [DIST_BITS-1:0]        rsp_raw_distance,
   input logic [DIST_BITS-1:0]        rsp_filtered_distance
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_channel)
         && $stable(rsp_raw_distance) && $stable(rsp_filtered_distance))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_fire_xor_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_trigger_fire && rsp_measurement_done))
      else $error("tick and measurement in one response");

   a_no_dist_without_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_measurement_done
         |-> rsp_raw_distance == '0 && rsp_filtered_distance == '0)
      else $error("distance reported without a measurement");

   // the input side only stalls while a response is being held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with the response side free");

endmodule

bind ultrasonic_echo_ranger_4ch_core uer4_checker u_uer4_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_out_channel       (rsp_out_channel),
   .rsp_trigger_fire      (rsp_trigger_fire),
   .rsp_measurement_done  (rsp_measurement_done),
   .rsp_raw_distance      (rsp_raw_distance),
   .rsp_filtered_distance (rsp_filtered_distance)
);

@@ dv/range_check_pkg.sv @@
`timescale 1ns / 1ps

package range_check_pkg;
   import uer4_pkg::*;

   localparam int CHANNELS  = 4;
   localparam int STAMP_MAX = 65535;

   typedef struct packed {
      logic [CHAN_FIELD_BITS-1:0] chan;
      logic                       fire;
      logic                       done;
      logic [DIST_BITS-1:0]       raw;
      logic [DIST_BITS-1:0]       filt;
   } range_result_type;

   class range_scoreboard;
      bit                         awaiting_fall [CHANNELS];
      logic [CAPTURE_BITS-1:0]    start_stamp [CHANNELS];
      logic [DIST_BITS-1:0]       newest [CHANNELS];
      logic [DIST_BITS-1:0]       prior [CHANNELS];
      logic [CHAN_FIELD_BITS-1:0] trigger_ptr;
      logic [LIMIT_BITS-1:0]      jump_limit;
      range_result_type           pending_ranges[$];
      int                         failures;

      function new();
         for (int c = 0; c < CHANNELS; c++) begin
            awaiting_fall[c] = 1'b0;
            start_stamp[c]   = '0;
            newest[c]        = '0;
            prior[c]         = '0;
         end
         trigger_ptr = '0;
         jump_limit  = JUMP_LIMIT_RESET;
         failures    = 0;
      endfunction

      function void note_request(opcode_type op, logic [CHAN_FIELD_BITS-1:0] chan,
                                 logic [CAPTURE_BITS-1:0] stamp);
         range_result_type r;
         int unsigned      width;
         int unsigned      dist_cm;
         int unsigned      diff;
         r = '0;
         if (op == OP_TICK) begin
            r.chan = trigger_ptr;
            r.fire = 1'b1;
            trigger_ptr = (trigger_ptr == CHANNELS - 1) ? '0 : trigger_ptr + 1'b1;
         end else begin
            r.chan = chan;
            if (!awaiting_fall[chan]) begin
               start_stamp[chan]   = stamp;
               awaiting_fall[chan] = 1'b1;
            end else begin
               if (stamp > start_stamp[chan])
                  width = stamp - start_stamp[chan];
               else
                  width = STAMP_MAX - start_stamp[chan] + stamp;
               dist_cm = width / CM_DIVISOR;
               if (dist_cm > DIST_MAX)
                  dist_cm = DIST_MAX;
               prior[chan]         = newest[chan];
               newest[chan]        = DIST_BITS'(dist_cm);
               awaiting_fall[chan] = 1'b0;
               diff = (newest[chan] > prior[chan]) ? newest[chan] - prior[chan]
                                                   : prior[chan] - newest[chan];
               r.done = 1'b1;
               r.raw  = newest[chan];
               r.filt = (diff > jump_limit) ? '0 : prior[chan];
            end
         end
         pending_ranges.push_back(r);
      endfunction

      function void compare_field(string label, int unsigned want, int unsigned got);
         if (want != got) begin
            failures++;
            $display("%0t %s expected %0d actual %0d", $time, label, want, got);
         end
      endfunction

      function void check_result(range_result_type got);
         range_result_type want;
         if (pending_ranges.size() == 0) begin
            failures++;
            $display("%0t unexpected transfer, expected none actual channel %0d",
                     $time, got.chan);
         end else begin
            want = pending_ranges.pop_front();
            compare_field("out_channel", want.chan, got.chan);
            compare_field("trigger_fire", want.fire, got.fire);
            compare_field("measurement_done", want.done, got.done);
            compare_field("raw_distance", want.raw, got.raw);
            compare_field("filtered_distance", want.filt, got.filt);
         end
      endfunction
   endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import uer4_pkg::*;
   import range_check_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_opcode = 1'b0;
   logic [CHAN_FIELD_BITS-1:0] req_channel = '0;
   logic [CAPTURE_BITS-1:0]    req_capture_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [CHAN_FIELD_BITS-1:0] rsp_out_channel;
   logic                       rsp_trigger_fire;
   logic                       rsp_measurement_done;
   logic [DIST_BITS-1:0]       rsp_raw_distance;
   logic [DIST_BITS-1:0]       rsp_filtered_distance;
   logic                       csr_write_enable = 1'b0;
   logic [LIMIT_BITS-1:0]      csr_write_data = '0;

   range_scoreboard board;
   int cycle_count = 0;
   int stall_mode = 0;
   int stall_run = 0;
   int stall_phase = 0;

   ultrasonic_echo_ranger_4ch_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_channel           (req_channel),
      .req_capture_value     (req_capture_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_channel       (rsp_out_channel),
      .rsp_trigger_fire      (rsp_trigger_fire),
      .rsp_measurement_done  (rsp_measurement_done),
      .rsp_raw_distance      (rsp_raw_distance),
      .rsp_filtered_distance (rsp_filtered_distance),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_out_channel, rsp_trigger_fire, rsp_measurement_done,
                             rsp_raw_distance, rsp_filtered_distance});
   end

   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(20, 200);
      end
      stall_run--;
      stall_phase = (stall_phase == 4) ? 0 : stall_phase + 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 25);
         2: rsp_stall <= ($urandom_range(0, 99) < 75);
         default: rsp_stall <= (stall_phase < 2);
      endcase
   end

   task automatic send_item(opcode_type op, logic [CHAN_FIELD_BITS-1:0] chan,
                            logic [CAPTURE_BITS-1:0] stamp);
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_channel       <= chan;
      req_capture_value <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(op, chan, stamp);
   endtask

   task automatic idle(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic settle();
      idle(1);
      while (board.pending_ranges.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_jump_limit(logic [LIMIT_BITS-1:0] value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      board.jump_limit = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CAPTURE_BITS-1:0] pick_stamp(logic [CHAN_FIELD_BITS-1:0] chan);
      int kind;
      int delta;
      int target;
      int width;
      kind = $urandom_range(0, 9);
      if (!board.awaiting_fall[chan] || kind == 6 || kind == 7)
         return ($urandom_range(0, 9) == 0) ? {CAPTURE_BITS{$urandom_range(0, 1) == 1}}
                                            : CAPTURE_BITS'($urandom);
      if (kind == 8)
         return board.start_stamp[chan];
      if (kind == 9)
         return ($urandom_range(0, 1) == 1) ? '1 : '0;
      delta = (kind < 4) ? $urandom_range(0, 120) : board.jump_limit + $urandom_range(0, 1);
      target = ($urandom_range(0, 1) == 1) ? board.newest[chan] + delta
                                           : board.newest[chan] - delta;
      if (target < 0)
         target = 0;
      if (target > 1129)
         target = 1129;
      width = target * CM_DIVISOR + $urandom_range(0, CM_DIVISOR - 1);
      if (width > STAMP_MAX)
         width = STAMP_MAX;
      if (width == 0)
         width = 1;
      return board.start_stamp[chan] + CAPTURE_BITS'(width);
   endfunction

   task automatic run_random(int count);
      int burst;
      opcode_type op;
      logic [CHAN_FIELD_BITS-1:0] chan;
      burst = $urandom_range(1, 20);
      for (int k = 0; k < count; k++) begin
         op   = ($urandom_range(0, 99) < 15) ? OP_TICK : OP_CAPTURE;
         chan = CHAN_FIELD_BITS'($urandom_range(0, CHANNELS - 1));
         if (op == OP_TICK)
            send_item(op, chan, CAPTURE_BITS'($urandom));
         else
            send_item(op, chan, pick_stamp(chan));
         burst--;
         if (burst == 0) begin
            idle($urandom_range(1, 12));
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
         end
      end
   endtask

   initial begin
      int limit_value;
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      repeat (5) send_item(OP_TICK, 2'd0, 16'h0000);
      send_item(OP_CAPTURE, 2'd0, 16'h0000);
      send_item(OP_CAPTURE, 2'd0, 16'hFFFF);
      send_item(OP_CAPTURE, 2'd1, 16'hFFFF);
      send_item(OP_CAPTURE, 2'd1, 16'h0000);
      // equal stamps measure the largest width, 65535
      send_item(OP_CAPTURE, 2'd2, 16'd1234);
      send_item(OP_CAPTURE, 2'd2, 16'd1234);
      send_item(OP_CAPTURE, 2'd3, 16'd5000);
      send_item(OP_CAPTURE, 2'd3, 16'd7900);
      send_item(OP_CAPTURE, 2'd3, 16'd100);
      send_item(OP_CAPTURE, 2'd3, 16'd11700);
      // jump exactly at the limit still trusted
      send_item(OP_CAPTURE, 2'd3, 16'd40000);
      send_item(OP_CAPTURE, 2'd3, 16'd57400);
      // timer wrap between edges
      send_item(OP_CAPTURE, 2'd0, 16'd65000);
      send_item(OP_CAPTURE, 2'd0, 16'd1000);
      send_item(OP_CAPTURE, 2'd1, 16'd300);
      send_item(OP_CAPTURE, 2'd1, 16'd357);
      send_item(OP_CAPTURE, 2'd1, 16'd300);
      send_item(OP_CAPTURE, 2'd1, 16'd358);
      send_item(OP_TICK, 2'd3, 16'hFFFF);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: limit_value = 0;
            1: limit_value = 2047;
            2: limit_value = 1129;
            default: limit_value = $urandom_range(0, 1129);
         endcase
         write_jump_limit(LIMIT_BITS'(limit_value));
         run_random(140);
      end

      settle();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending_ranges.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
